// ===== hdl/integral_histogram_builder_core_macros.svh =====
// ----------------------------------------------------------------------------
// integral histogram builder assertion macros
// concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef INTEGRAL_HISTOGRAM_BUILDER_CORE_MACROS_SVH
`define INTEGRAL_HISTOGRAM_BUILDER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define IHB_ASSERT_CLK(label, ck, rstn, prop) \
	label: assert property (@(posedge ck) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define IHB_ASSERT(label, prop) `IHB_ASSERT_CLK(label, clk, arst_n, prop)
`else
`define IHB_ASSERT_CLK(label, ck, rstn, prop)
`define IHB_ASSERT(label, prop)
`endif

`endif

// ===== hdl/ihb_pkg.sv =====
// ----------------------------------------------------------------------------
// ihb_pkg
// shared constants, codes and types of the integral histogram builder
// ----------------------------------------------------------------------------
package ihb_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_BINS   = 32;
	localparam int PIXEL_BITS = 8;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int BIN_W   = $clog2(MAX_BINS);
	localparam int BCNT_W  = 6;
	localparam int DIM_W   = 11;
	localparam int TOT_W   = 28;
	localparam int DEN_W   = PIXEL_BITS;
	localparam int NUM_W   = PIXEL_BITS + BIN_W;
	localparam int CNT_W   = $clog2(NUM_W);
	localparam int ADDR_W  = COL_W + BIN_W;
	localparam int MEM_DEPTH = MAX_WIDTH * MAX_BINS;

	localparam logic [DEN_W-1:0] PIX_MAX = DEN_W'((1 << PIXEL_BITS) - 1);

	// register indexes
	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_BIN_COUNT = 3'd1;
	localparam logic [2:0] REG_MAX_VALUE = 3'd2;
	localparam logic [2:0] REG_MAG_BINS  = 3'd3;
	localparam logic [2:0] REG_WIDTH     = 3'd4;
	localparam logic [2:0] REG_HEIGHT    = 3'd5;

	// accumulation modes
	localparam logic [1:0] MODE_COUNT  = 2'd0;
	localparam logic [1:0] MODE_WEIGHT = 2'd1;
	localparam logic [1:0] MODE_JOINT  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NVAL,
		ST_VBIN,
		ST_MBIN,
		ST_BIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

// ===== hdl/integral_histogram_builder_core.sv =====
// count and weighted modes divide once before the bins of a pixel, joint mode twice
// throughput: one bin result per cycle while the output is not stalled; a new pixel
// is taken only after the last bin of the previous one; the pace is set by the shared
// bit-serial divider and the single row store port pair that moves one bin per cycle
// reset clears config and control registers, left and corner totals, but not the row store
`include "integral_histogram_builder_core_macros.svh"
// ----------------------------------------------------------------------------
// integral_histogram_builder_core
// per pixel bin selection via a shared divider, then a bin sequencer that
// combines left, above and corner totals and updates the row store
// ----------------------------------------------------------------------------
module integral_histogram_builder_core import ihb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// pixel stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // pixel_value[7:0], magnitude[15:8]
	// histogram stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // column[9:0], row[19:10], bin_index[24:20], bin_total[52:25]
	output logic        m_tlast    // last
);

	// configuration
	logic [1:0]        mode_q;
	logic [BCNT_W-1:0] bin_count_q;
	logic [7:0]        max_value_q;
	logic [BCNT_W-1:0] mag_bins_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_COUNT;
			bin_count_q <= BCNT_W'(MAX_BINS);
			max_value_q <= 8'd255;
			mag_bins_q  <= BCNT_W'(1);
			width_q     <= DIM_W'(MAX_WIDTH);
			height_q    <= DIM_W'(MAX_HEIGHT);
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_MODE:      mode_q      <= pwdata[1:0];
				REG_BIN_COUNT: bin_count_q <= pwdata[BCNT_W-1:0];
				REG_MAX_VALUE: max_value_q <= pwdata[7:0];
				REG_MAG_BINS:  mag_bins_q  <= pwdata[BCNT_W-1:0];
				REG_WIDTH:     width_q     <= pwdata[DIM_W-1:0];
				REG_HEIGHT:    height_q    <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_MODE:      prdata = {30'd0, mode_q};
			REG_BIN_COUNT: prdata = {26'd0, bin_count_q};
			REG_MAX_VALUE: prdata = {24'd0, max_value_q};
			REG_MAG_BINS:  prdata = {26'd0, mag_bins_q};
			REG_WIDTH:     prdata = {21'd0, width_q};
			REG_HEIGHT:    prdata = {21'd0, height_q};
			default:       prdata = '0;
		endcase
	end

	// effective settings
	logic [BCNT_W-1:0] bins_eff;
	logic [BIN_W-1:0]  bins_m1;
	logic [DEN_W-1:0]  maxv_eff;
	logic [BCNT_W-1:0] nmag_eff;
	logic [BIN_W-1:0]  nmag_m1;
	logic [DIM_W-1:0]  width_eff;
	logic [DIM_W-1:0]  height_eff;
	logic              joint;

	always_comb begin
		if (bin_count_q == '0)
			bins_eff = BCNT_W'(1);
		else if (bin_count_q > BCNT_W'(MAX_BINS))
			bins_eff = BCNT_W'(MAX_BINS);
		else
			bins_eff = bin_count_q;
		if (mag_bins_q == '0)
			nmag_eff = BCNT_W'(1);
		else if (mag_bins_q > bins_eff)
			nmag_eff = bins_eff;
		else
			nmag_eff = mag_bins_q;
		if (width_q == '0)
			width_eff = DIM_W'(1);
		else if (width_q > DIM_W'(MAX_WIDTH))
			width_eff = DIM_W'(MAX_WIDTH);
		else
			width_eff = width_q;
		if (height_q == '0)
			height_eff = DIM_W'(1);
		else if (height_q > DIM_W'(MAX_HEIGHT))
			height_eff = DIM_W'(MAX_HEIGHT);
		else
			height_eff = height_q;
	end

	assign bins_m1  = BIN_W'(bins_eff - 1'b1);
	assign nmag_m1  = BIN_W'(nmag_eff - 1'b1);
	assign maxv_eff = (max_value_q == '0) ? DEN_W'(1) : max_value_q;
	assign joint    = mode_q == MODE_JOINT;

	// sequencer
	state_t state_q, state_d;

	logic [7:0]        val_q;
	logic [7:0]        mag_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_count_q;
	logic [ROW_W-1:0]  row_count_q;
	logic [BCNT_W-1:0] nval_q;
	logic [NUM_W-1:0]  vq_q;
	logic [BIN_W-1:0]  mq_q;
	logic [BIN_W-1:0]  bin_q;
	logic [BIN_W-1:0]  bidx_q;
	logic              started_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	ihb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	logic              in_xfer;
	logic              adv;
	logic              last_bin;
	logic              div_state;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;

	assign in_xfer  = s_tvalid && s_tready;
	assign last_bin = bidx_q == bins_m1;

	// bin selection
	logic [BIN_W-1:0]  nval_m1;
	logic [NUM_W:0]    vprod;
	logic [NUM_W:0]    mprod;
	logic [NUM_W:0]    mrecip;
	logic [BIN_W-1:0]  vb;
	logic [11:0]       jbin;
	logic [NUM_W-1:0]  raw_bin;
	logic [BIN_W-1:0]  bin_sel;

	assign nval_m1 = BIN_W'(nval_q - 1'b1);
	assign vprod   = (NUM_W+1)'(val_q) * (NUM_W+1)'(joint ? nval_m1 : bins_m1);
	assign mprod   = (NUM_W+1)'(mag_q) * (NUM_W+1)'(nmag_m1);
	// divide by the largest pixel level through its reciprocal
	assign mrecip  = mprod + (mprod >> PIXEL_BITS) + (NUM_W+1)'(1);
	assign vb      = (vq_q > NUM_W'(nval_m1)) ? nval_m1 : vq_q[BIN_W-1:0];
	assign jbin    = 12'(vb) + 12'(12'(mq_q) * 12'(nval_q));
	assign raw_bin = joint ? NUM_W'(jbin) : vq_q;
	assign bin_sel = (raw_bin > NUM_W'(bins_m1)) ? bins_m1 : raw_bin[BIN_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = joint ? ST_NVAL : ST_VBIN;
			ST_NVAL: if (div_rsp.done) state_d = ST_VBIN;
			ST_VBIN: if (div_rsp.done) state_d = joint ? ST_MBIN : ST_BIN;
			ST_MBIN: state_d = ST_BIN;
			ST_BIN:  state_d = ST_EMIT;
			ST_EMIT: if (adv && last_bin) state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		div_state   = 1'b0;
		div_req.num = '0;
		div_req.den = maxv_eff;
		adv         = 1'b0;
		mem_re      = 1'b0;
		mem_raddr   = {col_q, bidx_q};
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_NVAL: begin
				div_state   = 1'b1;
				div_req.num = NUM_W'(bins_eff);
				div_req.den = DEN_W'(nmag_eff);
			end
			ST_VBIN: begin
				div_state   = 1'b1;
				div_req.num = vprod[NUM_W-1:0];
			end
			ST_MBIN: ;
			ST_BIN: begin
				mem_re    = 1'b1;
				mem_raddr = {col_q, {BIN_W{1'b0}}};
			end
			ST_EMIT: begin
				adv       = !m_tvalid || m_tready;
				mem_re    = adv && !last_bin;
				mem_raddr = {col_q, BIN_W'(bidx_q + 1'b1)};
			end
		endcase
		div_req.start = div_state && !started_q && !div_rsp.busy && !div_rsp.done;
	end

	// per bin totals
	logic [TOT_W-1:0] row_mem [MEM_DEPTH];
	logic [TOT_W-1:0] rdata_q;
	logic [TOT_W-1:0] left_q [MAX_BINS];
	logic [TOT_W-1:0] diag_q [MAX_BINS];

	logic [TOT_W-1:0] above;
	logic [TOT_W-1:0] left_v;
	logic [TOT_W-1:0] corner;
	logic [TOT_W-1:0] add_v;
	logic [TOT_W-1:0] total;

	assign above  = (row_q != '0) ? rdata_q : '0;
	assign left_v = (col_q != '0) ? left_q[bidx_q] : '0;
	assign corner = (col_q != '0) ? diag_q[bidx_q] : '0;
	assign add_v  = (bidx_q != bin_q) ? '0 :
	                (mode_q == MODE_WEIGHT) ? TOT_W'(mag_q) : TOT_W'(1);
	assign total  = left_v + above - corner + add_v;

	always_ff @(posedge clk) begin
		if (adv)
			row_mem[{col_q, bidx_q}] <= total;
		if (mem_re)
			rdata_q <= row_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BINS; i++) begin
				left_q[i] <= '0;
				diag_q[i] <= '0;
			end
		end else if (adv) begin
			left_q[bidx_q] <= total;
			diag_q[bidx_q] <= above;
		end
	end

	// control registers
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;

	assign col_inc = DIM_W'(col_q) + 1'b1;
	assign row_inc = DIM_W'(row_q) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= 1'b0;
			col_count_q <= '0;
			row_count_q <= '0;
			bidx_q      <= '0;
		end else begin
			state_q <= state_d;
			if (div_req.start)
				started_q <= 1'b1;
			else if (div_rsp.done)
				started_q <= 1'b0;
			if (state_q == ST_BIN)
				bidx_q <= '0;
			else if (adv && !last_bin)
				bidx_q <= bidx_q + 1'b1;
			if (adv && last_bin) begin
				if (col_inc >= width_eff) begin
					col_count_q <= '0;
					row_count_q <= (row_inc >= height_eff) ? '0 : row_inc[ROW_W-1:0];
				end else begin
					col_count_q <= col_inc[COL_W-1:0];
					row_count_q <= row_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			val_q <= s_tdata[7:0];
			mag_q <= s_tdata[15:8];
			col_q <= (DIM_W'(col_count_q) >= width_eff) ? '0 : col_count_q;
			row_q <= (DIM_W'(row_count_q) >= height_eff) ? '0 : row_count_q;
		end
		if (div_rsp.done) begin
			if (state_q == ST_NVAL)
				nval_q <= div_rsp.quo[BCNT_W-1:0];
			if (state_q == ST_VBIN)
				vq_q <= div_rsp.quo;
		end
		if (state_q == ST_MBIN)
			mq_q <= mrecip[PIXEL_BITS +: BIN_W];
		if (state_q == ST_BIN)
			bin_q <= bin_sel;
	end

	// output register
	logic              m_valid_q;
	logic [COL_W-1:0]  o_col_q;
	logic [ROW_W-1:0]  o_row_q;
	logic [BIN_W-1:0]  o_bin_q;
	logic [TOT_W-1:0]  o_total_q;
	logic              o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (adv)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			o_col_q   <= col_q;
			o_row_q   <= row_q;
			o_bin_q   <= bidx_q;
			o_total_q <= total;
			o_last_q  <= last_bin;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'd0, o_total_q, o_bin_q, o_row_q, o_col_q};
	assign m_tlast  = o_last_q;

	// checks
	`IHB_ASSERT(a_busy_after_accept, in_xfer |=> state_q != ST_IDLE)
	`IHB_ASSERT(a_bin_in_range, (state_q == ST_EMIT) |-> (bin_q <= bins_m1))
	`IHB_ASSERT(a_idx_in_range, (state_q == ST_EMIT) |-> (bidx_q <= bins_m1))
	`IHB_ASSERT(a_last_ends_pixel, (adv && last_bin) |=> (state_q == ST_IDLE) && m_tlast)
	`IHB_ASSERT(a_div_only_in_seq, div_req.start |-> !div_rsp.busy && (state_q != ST_EMIT))

endmodule

// ===== hdl/ihb_div.sv =====
// ----------------------------------------------------------------------------
// ihb_div
// restoring divider, one quotient bit per cycle, shared by the bin sequencer
// ----------------------------------------------------------------------------
module ihb_div import ihb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

endmodule
